FILE: rtl/zbfs_pkg.sv
// shared constants, types and codes of the z-buffer forward-warp splat store
`timescale 1ns / 1ps
`default_nettype none

package zbfs_pkg;

    // store geometry and source coordinate format
    localparam int MAX_COLS        = 512;
    localparam int MAX_ROWS        = 512;
    localparam int COORD_FRAC_BITS = 4;

    localparam int STORE_SIZE = MAX_COLS * MAX_ROWS;
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int ADDR_BITS  = $clog2(STORE_SIZE);

    // field widths
    localparam int OPCODE_W   = 2;
    localparam int TARGET_W   = 12;
    localparam int SRC_W      = 16;
    localparam int DEPTH_W    = 24;
    localparam int STATUS_W   = 3;
    localparam int SIZE_W     = 10;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LIM_W      = 13;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    localparam logic signed [SRC_W:0] COORD_ONE = (SRC_W + 1)'(1 << COORD_FRAC_BITS);

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_SPLAT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OCCLUDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OOB      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TOL    = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic [TOL_W-1:0]  depth_tolerance;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_SPLAT,
        CMD_READ,
        CMD_OOB,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        logic [ADDR_BITS-1:0]     addr;
        logic signed [SRC_W-1:0]  src_col;
        logic signed [SRC_W-1:0]  src_row;
        logic [DEPTH_W-1:0]       inv_depth;
    } t_cmd;

    typedef struct packed {
        logic                     valid;
        logic signed [SRC_W-1:0]  col;
        logic signed [SRC_W-1:0]  row;
        logic [DEPTH_W-1:0]       depth;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     entry_valid;
        logic signed [SRC_W-1:0]  entry_col;
        logic signed [SRC_W-1:0]  entry_row;
        logic [DEPTH_W-1:0]       entry_depth;
    } t_result;

    typedef enum logic [1:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_EXEC
    } t_back_state;

endpackage

`default_nettype wire

FILE: rtl/zbfs_ifs.sv
// valid/ready channel interfaces of the splat store: item input, result output, config write
`timescale 1ns / 1ps
`default_nettype none

interface zbfs_in_if import zbfs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic signed [TARGET_W-1:0] target_col;
    logic signed [TARGET_W-1:0] target_row;
    logic signed [SRC_W-1:0] source_col;
    logic signed [SRC_W-1:0] source_row;
    logic [DEPTH_W-1:0]      inv_depth;

    modport source (output valid, opcode, target_col, target_row, source_col, source_row,
                    inv_depth, input ready);
    modport sink   (input valid, opcode, target_col, target_row, source_col, source_row,
                    inv_depth, output ready);
endinterface

interface zbfs_out_if import zbfs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic                    entry_valid;
    logic signed [SRC_W-1:0] entry_col;
    logic signed [SRC_W-1:0] entry_row;
    logic [DEPTH_W-1:0]      entry_depth;

    modport source (output valid, status, entry_valid, entry_col, entry_row, entry_depth,
                    input ready);
    modport sink   (input valid, status, entry_valid, entry_col, entry_row, entry_depth,
                    output ready);
endinterface

interface zbfs_cfg_if import zbfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/zbuffer_forward_splat.sv
// top level of the z-buffer forward-warp splat store
`timescale 1ns / 1ps
`default_nettype none

// Z-buffer forward-warp splat store with one entry per pixel of a MAX_COLS x MAX_ROWS
// frame (262144 entries by default), held in one single-port-write memory. Each input
// beat is a splat, a read or a clear; opcode 3 is taken and dropped without a result.
// A front end bounds-checks the target against frame_width/frame_height and forms the
// entry address, then hands a command through a four-deep queue to the store engine,
// so the input keeps taking beats while the engine or the output is busy, until the
// queue is full. Per item in the engine: an out-of-bounds splat or read is answered
// from the idle state; an in-bounds splat or read does one registered memory read,
// then decides and writes back, a read-modify-write of the entry memory; a clear
// leaves the queue and then walks the whole memory entry by entry, reporting on the
// last entry. Each result waits while the output register is full and not taken.
// After reset the engine runs the same sweep with no result; beats queue up meanwhile,
// until the queue is full, and config writes are taken as ever. Results leave through a
// registered output that holds while o_out.ready is low. Config registers are to be
// written only while the block is idle.
module zbuffer_forward_splat import zbfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zbfs_in_if.sink     i_in,
    zbfs_out_if.source  o_out,
    zbfs_cfg_if.sink    i_cfg
);

    t_cfg  r_cfg;
    logic  q_push;
    t_cmd  q_data;
    logic  q_full;
    logic  q_pop;
    logic  q_head_valid;
    t_cmd  q_head;

    // config port, always ready; writes beyond the register list are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width     <= SIZE_W'(512);
            r_cfg.frame_height    <= SIZE_W'(512);
            r_cfg.depth_tolerance <= TOL_W'(33);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_cfg.frame_width     <= i_cfg.data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height    <= i_cfg.data[SIZE_W-1:0];
                CFG_DEPTH_TOL:    r_cfg.depth_tolerance <= i_cfg.data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end: classify and address
    zbfs_front u_front (
        .i_in       (i_in),
        .i_cfg_regs (r_cfg),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_data)
    );

    // decoupling queue
    zbfs_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_data  (q_data),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // store engine and result register
    zbfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_regs   (r_cfg),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out        (o_out)
    );

`ifndef SYNTHESIS
    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head_valid)
        else $error("command popped from empty queue");

    // out-of-bounds and clear beats carry an empty entry
    a_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_OOB || o_out.status == ST_CLEARED))
        |-> (!o_out.entry_valid && o_out.entry_col == '0 && o_out.entry_row == '0
             && o_out.entry_depth == '0))
        else $error("empty-entry result shows entry data");

    // a splat that lands always leaves or meets a valid entry
    a_splat_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_STORED || o_out.status == ST_MERGED
                         || o_out.status == ST_OCCLUDED))
        |-> o_out.entry_valid)
        else $error("splat result without valid entry");
`endif

endmodule

`default_nettype wire

FILE: rtl/zbfs_front.sv
// front end: accepts item beats, bounds-checks the target and builds store commands
`timescale 1ns / 1ps
`default_nettype none

module zbfs_front import zbfs_pkg::*; (
    zbfs_in_if.sink  i_in,
    input  t_cfg     i_cfg_regs,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_data
);

    logic [LIM_W-1:0]    w_lim;
    logic [LIM_W-1:0]    h_lim;
    logic                oob;
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;

    assign i_in.ready = !i_q_full;

    // active size limited to the store size
    assign w_lim = (LIM_W'(i_cfg_regs.frame_width) < LIM_W'(MAX_COLS))
                   ? LIM_W'(i_cfg_regs.frame_width) : LIM_W'(MAX_COLS);
    assign h_lim = (LIM_W'(i_cfg_regs.frame_height) < LIM_W'(MAX_ROWS))
                   ? LIM_W'(i_cfg_regs.frame_height) : LIM_W'(MAX_ROWS);

    assign oob = i_in.target_col[TARGET_W-1] || i_in.target_row[TARGET_W-1]
              || (LIM_W'(i_in.target_col[TARGET_W-2:0]) >= w_lim)
              || (LIM_W'(i_in.target_row[TARGET_W-2:0]) >= h_lim);

    assign col = i_in.target_col[COL_BITS-1:0];
    assign row = i_in.target_row[ROW_BITS-1:0];

    always_comb begin
        o_q_data.addr      = ADDR_BITS'(ADDR_BITS'(row) * ADDR_BITS'(MAX_COLS))
                           + ADDR_BITS'(col);
        o_q_data.src_col   = i_in.source_col;
        o_q_data.src_row   = i_in.source_row;
        o_q_data.inv_depth = i_in.inv_depth;
        if (i_in.opcode == OP_CLEAR) begin
            o_q_data.kind = CMD_CLEAR;
        end else if (oob) begin
            o_q_data.kind = CMD_OOB;
        end else if (i_in.opcode == OP_READ) begin
            o_q_data.kind = CMD_READ;
        end else begin
            o_q_data.kind = CMD_SPLAT;
        end
    end

    // unused opcode is taken and dropped
    assign o_q_push = i_in.valid && !i_q_full && (i_in.opcode != OP_NONE);

endmodule

`default_nettype wire

FILE: rtl/zbfs_fifo.sv
// short command queue between the front end and the store engine
`timescale 1ns / 1ps
`default_nettype none

module zbfs_fifo import zbfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_cmd o_head
);

    t_cmd                   r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_PTR_BITS:0]   r_count;

    assign o_full       = (r_count == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= FIFO_PTR_BITS'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= FIFO_PTR_BITS'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/zbfs_back.sv
// store engine: entry memory, read-modify-write of splats, clear sweep, result register
`timescale 1ns / 1ps
`default_nettype none

module zbfs_back import zbfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg_regs,
    input  logic        i_head_valid,
    input  t_cmd        i_head,
    output logic        o_pop,
    zbfs_out_if.source  o_out
);

    t_entry               r_mem [STORE_SIZE];
    t_entry               r_rd_data;

    t_back_state          r_state, n_state;
    logic [ADDR_BITS-1:0] r_sweep_addr, n_sweep_addr;
    logic                 r_sweep_op, n_sweep_op;
    t_cmd                 r_cmd, n_cmd;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    t_entry               mem_wdata;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 can_emit;
    logic                 emit;
    t_result              emit_data;

    logic signed [SRC_W:0] col_diff, row_diff, col_sum, row_sum;
    logic [DEPTH_W-1:0]    dep_diff;
    logic [DEPTH_W:0]      dep_sum;
    logic                  occluded, near, merge;
    t_entry                merged, fresh;

    assign can_emit = !r_out_valid || o_out.ready;

    // splat decision on the entry just read
    always_comb begin
        col_diff = {r_cmd.src_col[SRC_W-1], r_cmd.src_col} - {r_rd_data.col[SRC_W-1], r_rd_data.col};
        row_diff = {r_cmd.src_row[SRC_W-1], r_cmd.src_row} - {r_rd_data.row[SRC_W-1], r_rd_data.row};
        col_sum  = {r_cmd.src_col[SRC_W-1], r_cmd.src_col} + {r_rd_data.col[SRC_W-1], r_rd_data.col};
        row_sum  = {r_cmd.src_row[SRC_W-1], r_cmd.src_row} + {r_rd_data.row[SRC_W-1], r_rd_data.row};
        dep_diff = r_cmd.inv_depth - r_rd_data.depth;
        dep_sum  = {1'b0, r_cmd.inv_depth} + {1'b0, r_rd_data.depth};
        occluded = r_rd_data.valid && (r_rd_data.depth > r_cmd.inv_depth);
        near     = (col_diff < COORD_ONE) && (col_diff > -COORD_ONE)
                && (row_diff < COORD_ONE) && (row_diff > -COORD_ONE)
                && (dep_diff < DEPTH_W'(i_cfg_regs.depth_tolerance));
        merge    = r_rd_data.valid && !occluded && near;

        merged.valid = 1'b1;
        merged.col   = col_sum[SRC_W:1];
        merged.row   = row_sum[SRC_W:1];
        merged.depth = dep_sum[DEPTH_W:1];

        fresh.valid  = 1'b1;
        fresh.col    = r_cmd.src_col;
        fresh.row    = r_cmd.src_row;
        fresh.depth  = r_cmd.inv_depth;
    end

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_sweep_op   = r_sweep_op;
        n_cmd        = r_cmd;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_cmd.addr;
        mem_wdata    = fresh;
        rd_addr      = i_head.addr;
        emit         = 1'b0;
        emit_data    = '0;

        unique case (r_state)
            BK_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep_addr;
                mem_wdata = '0;
                if (r_sweep_addr == ADDR_BITS'(STORE_SIZE - 1)) begin
                    if (!r_sweep_op) begin
                        n_state = BK_IDLE;
                    end else if (can_emit) begin
                        emit             = 1'b1;
                        emit_data.status = ST_CLEARED;
                        n_state          = BK_IDLE;
                    end
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end
            BK_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.kind) inside
                        CMD_CLEAR: begin
                            o_pop        = 1'b1;
                            n_sweep_addr = '0;
                            n_sweep_op   = 1'b1;
                            n_state      = BK_SWEEP;
                        end
                        CMD_OOB: begin
                            if (can_emit) begin
                                o_pop            = 1'b1;
                                emit             = 1'b1;
                                emit_data.status = ST_OOB;
                            end
                        end
                        CMD_READ, CMD_SPLAT: begin
                            o_pop   = 1'b1;
                            n_cmd   = i_head;
                            n_state = BK_EXEC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_EXEC: begin
                // keep reading the same entry while the result waits
                rd_addr = r_cmd.addr;
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = BK_IDLE;
                    if (r_cmd.kind == CMD_READ) begin
                        emit_data.status = ST_READ;
                        if (r_rd_data.valid) begin
                            emit_data.entry_valid = 1'b1;
                            emit_data.entry_col   = r_rd_data.col;
                            emit_data.entry_row   = r_rd_data.row;
                            emit_data.entry_depth = r_rd_data.depth;
                        end
                    end else if (occluded) begin
                        emit_data.status      = ST_OCCLUDED;
                        emit_data.entry_valid = 1'b1;
                        emit_data.entry_col   = r_rd_data.col;
                        emit_data.entry_row   = r_rd_data.row;
                        emit_data.entry_depth = r_rd_data.depth;
                    end else begin
                        mem_we                = 1'b1;
                        mem_wdata             = merge ? merged : fresh;
                        emit_data.status      = merge ? ST_MERGED : ST_STORED;
                        emit_data.entry_valid = 1'b1;
                        emit_data.entry_col   = mem_wdata.col;
                        emit_data.entry_row   = mem_wdata.row;
                        emit_data.entry_depth = mem_wdata.depth;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_SWEEP;
            r_sweep_addr <= '0;
            r_sweep_op   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_op   <= n_sweep_op;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    // entry memory, read before write
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.entry_valid = r_out.entry_valid;
    assign o_out.entry_col   = r_out.entry_col;
    assign o_out.entry_row   = r_out.entry_row;
    assign o_out.entry_depth = r_out.entry_depth;

endmodule

`default_nettype wire
